/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the allocator RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted
`define PBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define PBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/pba_pkg.sv */
// ----------------------------------------------------------------------------
// pba_pkg
// Shared widths, codes and reset values of the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int AW     = 48;   // byte address width
  localparam int SW     = 32;   // byte count and alignment width
  localparam int CFGW   = 36;   // page frame number width
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 4;

  localparam int PAGE_COUNT_DEF = 4096;
  localparam int PAGE_BITS_DEF  = 12;

  localparam logic [CFGW-1:0] NODE_START_RST = 36'd0;
  localparam logic [CFGW-1:0] NODE_END_RST   = 36'd4096;

  localparam logic [1:0] CMD_RESERVE = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_ALLOC   = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_DFREE   = 2'd3;

  localparam logic REG_NODE_START = 1'b0;
  localparam logic REG_NODE_END   = 1'b1;

endpackage

/* rtl/pba_cfg.sv */
// ----------------------------------------------------------------------------
// pba_cfg
// APB register file holding the node page range.
// ----------------------------------------------------------------------------
module pba_cfg
  import pba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output logic [CFGW-1:0]   node_start,
  output logic [CFGW-1:0]   node_end
);

  logic [CFGW-1:0] start_r, start_nxt;
  logic [CFGW-1:0] end_r, end_nxt;
  logic            wr_en;
  logic            reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[CFG_AW-1];

  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_NODE_START: start_nxt = cfg_pwdata[CFGW-1:0];
        REG_NODE_END:   end_nxt   = cfg_pwdata[CFGW-1:0];
        default:        start_nxt = start_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= NODE_START_RST;
      end_r   <= NODE_END_RST;
    end else begin
      start_r <= start_nxt;
      end_r   <= end_nxt;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_NODE_START: cfg_prdata = CFG_DW'(start_r);
      REG_NODE_END:   cfg_prdata = CFG_DW'(end_r);
      default:        cfg_prdata = '0;
    endcase
  end

  assign node_start = start_r;
  assign node_end   = end_r;

endmodule

/* rtl/pba_map_ram.sv */
// ----------------------------------------------------------------------------
// pba_map_ram
// One bit per page, one write and one registered read port.
// ----------------------------------------------------------------------------
module pba_map_ram
  import pba_pkg::*;
#(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF,
  parameter int IW         = $clog2(PAGE_COUNT)
) (
  input  logic          clk,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output logic          rdata,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic          wdata
);

  logic mem [PAGE_COUNT];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/pba_engine.sv */
// ----------------------------------------------------------------------------
// pba_engine
// Command sequencer: range reserve/free and first-fit allocation over the
// page bitmap, one memory access per step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pba_engine
  import pba_pkg::*;
#(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  parameter int IW         = $clog2(PAGE_COUNT)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_command,
  input  logic [AW-1:0]   in_address,
  input  logic [SW-1:0]   in_byte_count,
  input  logic [SW-1:0]   in_alignment,
  input  logic [AW-1:0]   in_preferred_address,
  input  logic [AW-1:0]   in_upper_limit,
  input  logic            in_exclusive,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_status,
  output logic [AW-1:0]   out_region_address,
  input  logic [CFGW-1:0] node_start,
  input  logic [CFGW-1:0] node_end,
  output logic            map_re,
  output logic [IW-1:0]   map_raddr,
  input  logic            map_rdata,
  output logic            map_we,
  output logic [IW-1:0]   map_waddr,
  output logic            map_wdata
);

  localparam int PW = ((AW - PAGE_BITS) > CFGW ? (AW - PAGE_BITS) : CFGW) + 2;
  localparam int OW = ((IW + PAGE_BITS) > SW ? (IW + PAGE_BITS) : SW) + 2;
  localparam int LW = CFGW + PAGE_BITS + 1;
  localparam logic [PW-1:0] PC_P   = PW'(PAGE_COUNT);
  localparam logic [LW-1:0] PSM1_L = (LW'(1) << PAGE_BITS) - LW'(1);
  localparam logic [OW-1:0] PSM1_O = (OW'(1) << PAGE_BITS) - OW'(1);

  typedef enum logic [19:0] {
    S_IDLE  = 20'b00000000000000000001,
    S_FILL  = 20'b00000000000000000010,
    S_DONE  = 20'b00000000000000000100,
    S_RF1   = 20'b00000000000000001000,
    S_RF2   = 20'b00000000000000010000,
    S_RC_RD = 20'b00000000000000100000,
    S_RC_EV = 20'b00000000000001000000,
    S_FR_RD = 20'b00000000000010000000,
    S_FR_EV = 20'b00000000000100000000,
    S_AL1   = 20'b00000000001000000000,
    S_AL2   = 20'b00000000010000000000,
    S_AL3   = 20'b00000000100000000000,
    S_SK_RD = 20'b00000001000000000000,
    S_SK_EV = 20'b00000010000000000000,
    S_ALIGN = 20'b00000100000000000000,
    S_CK_RD = 20'b00001000000000000000,
    S_CK_EV = 20'b00010000000000000000,
    S_TAIL1 = 20'b00100000000000000000,
    S_TAIL2 = 20'b01000000000000000000,
    S_TAIL3 = 20'b10000000000000000000
  } state_t;

  function automatic logic [PW-1:0] rnd_up(input logic [PW-1:0] x, input logic [PW-1:0] st);
    rnd_up = (x + st - PW'(1)) & ~(st - PW'(1));
  endfunction

  // control
  state_t          state_r, state_nxt;
  logic            clr_r, clr_nxt;
  logic [PW-1:0]   i_r, i_nxt;
  logic [PW-1:0]   e_r, e_nxt;
  logic [PW-1:0]   s_r, s_nxt;
  logic            fill_r, fill_nxt;
  logic            dbl_r, dbl_nxt;
  logic            retry_r, retry_nxt;
  logic [PW-1:0]   hint_r, hint_nxt;
  logic [OW-1:0]   last_r, last_nxt;
  logic            out_valid_r, out_valid_nxt;
  // payload
  logic [1:0]      cmd_r, cmd_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [SW-1:0]   size_r, size_nxt;
  logic [SW-1:0]   align_r, align_nxt;
  logic [AW-1:0]   goal_r, goal_nxt;
  logic [AW-1:0]   limit_r, limit_nxt;
  logic            excl_r, excl_nxt;
  logic [PW-1:0]   np_r, np_nxt;
  logic [LW-1:0]   endb_r, endb_nxt;
  logic [PW-1:0]   aup_r, aup_nxt;
  logic [SW-1:0]   bal_r, bal_nxt;
  logic [PW-1:0]   step_r, step_nxt;
  logic [PW-1:0]   gp_r, gp_nxt;
  logic [PW-1:0]   maxp_r, maxp_nxt;
  logic [PW-1:0]   need_r, need_nxt;
  logic [PW-1:0]   midx_r, midx_nxt;
  logic [OW-1:0]   so_r, so_nxt;
  logic [OW-1:0]   eo_r, eo_nxt;
  logic [1:0]      st_r, st_nxt;
  logic [AW-1:0]   region_r, region_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  logic [AW-1:0]   out_region_r, out_region_nxt;

  logic [LW-1:0]   base;
  logic [PW-1:0]   minp;
  logic [PW-1:0]   endp;

  assign base = LW'(node_start) << PAGE_BITS;
  assign minp = PW'(node_start);
  assign endp = PW'(node_end);

  always_comb begin
    logic [PW-1:0] diff, rs, re_, fs, fe, hb, lp, sa, ea, nn, start, sidx, sop, hnt;
    logic [LW-1:0] relend, abase;
    logic [SW-1:0] a, stp;
    logic          outside, mrg, tail;

    state_nxt      = state_r;
    clr_nxt        = clr_r;
    i_nxt          = i_r;
    e_nxt          = e_r;
    s_nxt          = s_r;
    fill_nxt       = fill_r;
    dbl_nxt        = dbl_r;
    retry_nxt      = retry_r;
    hint_nxt       = hint_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r;
    cmd_nxt        = cmd_r;
    addr_nxt       = addr_r;
    size_nxt       = size_r;
    align_nxt      = align_r;
    goal_nxt       = goal_r;
    limit_nxt      = limit_r;
    excl_nxt       = excl_r;
    np_nxt         = np_r;
    endb_nxt       = endb_r;
    aup_nxt        = aup_r;
    bal_nxt        = bal_r;
    step_nxt       = step_r;
    gp_nxt         = gp_r;
    maxp_nxt       = maxp_r;
    need_nxt       = need_r;
    midx_nxt       = midx_r;
    so_nxt         = so_r;
    eo_nxt         = eo_r;
    st_nxt         = st_r;
    region_nxt     = region_r;
    out_status_nxt = out_status_r;
    out_region_nxt = out_region_r;

    diff    = endp - minp;
    relend  = endb_r - base;
    abase   = LW'(addr_r) - base;
    outside = (endb_r < base) || (PW'(addr_r >> PAGE_BITS) > endp);
    rs      = (LW'(addr_r) > base) ? PW'(abase >> PAGE_BITS) : '0;
    re_     = PW'((relend + PSM1_L) >> PAGE_BITS);
    fs      = (aup_r > minp) ? (aup_r - minp) : '0;
    fe      = PW'(relend >> PAGE_BITS);
    hb      = PW'(abase >> PAGE_BITS);
    a       = align_r & (~align_r + SW'(1));
    stp     = a >> PAGE_BITS;
    lp      = PW'(limit_r >> PAGE_BITS);
    sa      = rnd_up(s_r, step_r);
    ea      = sa + need_r;
    nn      = rnd_up(i_r, step_r);
    start   = ((gp_r != '0) && (minp < gp_r) && (gp_r < maxp_r)) ?
              rnd_up(gp_r, step_r) : rnd_up(minp, step_r);
    sidx    = s_r - minp;
    sop     = PW'(so_r >> PAGE_BITS);
    mrg     = sop < s_r;
    tail    = (last_r[PAGE_BITS-1:0] != '0) &&
              ((PW'(last_r >> PAGE_BITS) + PW'(1)) == s_r);
    hnt     = PW'((eo_r + PSM1_O) >> PAGE_BITS);

    // drop the result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_command;
          addr_nxt   = in_address;
          size_nxt   = (in_byte_count == '0) ? SW'(1) : in_byte_count;
          align_nxt  = in_alignment;
          goal_nxt   = in_preferred_address;
          limit_nxt  = in_upper_limit;
          excl_nxt   = in_exclusive;
          st_nxt     = ST_OK;
          region_nxt = '0;
          case (in_command) inside
            CMD_RESERVE, CMD_FREE: state_nxt = S_RF1;
            CMD_ALLOC:             state_nxt = S_AL1;
            default:               state_nxt = S_DONE;
          endcase
        end
      end
      S_RF1: begin
        endb_nxt  = LW'(addr_r) + LW'(size_r);
        aup_nxt   = PW'((LW'(addr_r) + PSM1_L) >> PAGE_BITS);
        np_nxt    = (endp > minp) ? ((diff > PC_P) ? PC_P : diff) : '0;
        state_nxt = S_RF2;
      end
      S_RF2: begin
        if (outside) begin
          state_nxt = S_DONE;
        end else if (cmd_r == CMD_RESERVE) begin
          i_nxt     = rs;
          s_nxt     = rs;
          e_nxt     = (re_ > np_r) ? np_r : re_;
          fill_nxt  = 1'b1;
          state_nxt = excl_r ? S_RC_RD : S_FILL;
        end else begin
          if ((LW'(addr_r) >= base) && (hb < hint_r)) begin
            hint_nxt = hb;
          end
          i_nxt     = fs;
          e_nxt     = (fe > np_r) ? np_r : fe;
          dbl_nxt   = 1'b0;
          state_nxt = S_FR_RD;
        end
      end
      S_RC_RD: begin
        if (i_r < e_r) begin
          state_nxt = S_RC_EV;
        end else begin
          i_nxt     = s_r;
          state_nxt = S_FILL;
        end
      end
      S_RC_EV: begin
        if (map_rdata) begin
          st_nxt    = ST_BUSY;
          state_nxt = S_DONE;
        end else begin
          i_nxt     = i_r + PW'(1);
          state_nxt = S_RC_RD;
        end
      end
      S_FR_RD: begin
        if (i_r < e_r) begin
          state_nxt = S_FR_EV;
        end else begin
          st_nxt    = dbl_r ? ST_DFREE : ST_OK;
          state_nxt = S_DONE;
        end
      end
      S_FR_EV: begin
        if (!map_rdata) begin
          dbl_nxt = 1'b1;
        end
        i_nxt     = i_r + PW'(1);
        state_nxt = S_FR_RD;
      end
      S_FILL: begin
        if (i_r < e_r) begin
          i_nxt = i_r + PW'(1);
        end else if (clr_r) begin
          clr_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_AL1: begin
        bal_nxt   = (a != '0) ? a : SW'(1);
        step_nxt  = (stp != '0) ? PW'(stp) : PW'(1);
        gp_nxt    = PW'(goal_r >> PAGE_BITS);
        maxp_nxt  = ((lp != '0) && (endp > lp)) ? lp : endp;
        need_nxt  = PW'((LW'(size_r) + PSM1_L) >> PAGE_BITS);
        state_nxt = S_AL2;
      end
      S_AL2: begin
        if (maxp_r <= minp) begin
          st_nxt    = ST_NOSPACE;
          state_nxt = S_DONE;
        end else begin
          s_nxt     = start;
          midx_nxt  = ((maxp_r - minp) > PC_P) ? PC_P : (maxp_r - minp);
          retry_nxt = gp_r != '0;
          state_nxt = S_AL3;
        end
      end
      S_AL3: begin
        if (hint_r > sidx) begin
          retry_nxt = 1'b1;
          s_nxt     = rnd_up(hint_r, step_r);
        end else begin
          s_nxt = sidx;
        end
        state_nxt = S_SK_RD;
      end
      S_SK_RD: begin
        state_nxt = (s_r < midx_r) ? S_SK_EV : S_ALIGN;
      end
      S_SK_EV: begin
        if (map_rdata) begin
          s_nxt     = s_r + PW'(1);
          state_nxt = S_SK_RD;
        end else begin
          state_nxt = S_ALIGN;
        end
      end
      S_ALIGN: begin
        if ((sa >= midx_r) || (ea > midx_r)) begin
          if (retry_r) begin
            retry_nxt = 1'b0;
            s_nxt     = '0;
            state_nxt = S_SK_RD;
          end else begin
            st_nxt    = ST_NOSPACE;
            state_nxt = S_DONE;
          end
        end else begin
          s_nxt     = sa;
          i_nxt     = sa;
          e_nxt     = ea;
          state_nxt = S_CK_RD;
        end
      end
      S_CK_RD: begin
        state_nxt = S_CK_EV;
      end
      S_CK_EV: begin
        if (map_rdata) begin
          s_nxt     = (nn == i_r) ? (i_r + step_r) : nn;
          state_nxt = S_SK_RD;
        end else if ((i_r + PW'(1)) == e_r) begin
          state_nxt = S_TAIL1;
        end else begin
          i_nxt     = i_r + PW'(1);
          state_nxt = S_CK_RD;
        end
      end
      S_TAIL1: begin
        // share the partly used page left by the previous allocation
        so_nxt    = tail ? ((last_r + OW'(bal_r) - OW'(1)) & ~(OW'(bal_r) - OW'(1)))
                         : (OW'(s_r) << PAGE_BITS);
        state_nxt = S_TAIL2;
      end
      S_TAIL2: begin
        eo_nxt     = so_r + OW'(size_r);
        i_nxt      = sop + PW'(mrg);
        region_nxt = AW'(base + LW'(so_r));
        state_nxt  = S_TAIL3;
      end
      S_TAIL3: begin
        last_nxt  = eo_r;
        hint_nxt  = hnt;
        e_nxt     = (hnt < midx_r) ? hnt : midx_r;
        fill_nxt  = 1'b1;
        state_nxt = S_FILL;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_region_nxt = region_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      clr_r       <= 1'b1;
      i_r         <= '0;
      e_r         <= PC_P;
      s_r         <= '0;
      fill_r      <= 1'b1;
      dbl_r       <= 1'b0;
      retry_r     <= 1'b0;
      hint_r      <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      i_r         <= i_nxt;
      e_r         <= e_nxt;
      s_r         <= s_nxt;
      fill_r      <= fill_nxt;
      dbl_r       <= dbl_nxt;
      retry_r     <= retry_nxt;
      hint_r      <= hint_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    addr_r       <= addr_nxt;
    size_r       <= size_nxt;
    align_r      <= align_nxt;
    goal_r       <= goal_nxt;
    limit_r      <= limit_nxt;
    excl_r       <= excl_nxt;
    np_r         <= np_nxt;
    endb_r       <= endb_nxt;
    aup_r        <= aup_nxt;
    bal_r        <= bal_nxt;
    step_r       <= step_nxt;
    gp_r         <= gp_nxt;
    maxp_r       <= maxp_nxt;
    need_r       <= need_nxt;
    midx_r       <= midx_nxt;
    so_r         <= so_nxt;
    eo_r         <= eo_nxt;
    st_r         <= st_nxt;
    region_r     <= region_nxt;
    out_status_r <= out_status_nxt;
    out_region_r <= out_region_nxt;
  end

  // memory access: one read or one write per step
  assign map_re    = ((state_r == S_SK_RD) && (s_r < midx_r)) || (state_r == S_CK_RD) ||
                     (((state_r == S_RC_RD) || (state_r == S_FR_RD)) && (i_r < e_r));
  assign map_raddr = (state_r == S_SK_RD) ? s_r[IW-1:0] : i_r[IW-1:0];
  assign map_we    = ((state_r == S_FILL) && (i_r < e_r)) || (state_r == S_FR_EV);
  assign map_waddr = i_r[IW-1:0];
  assign map_wdata = (state_r == S_FILL) ? fill_r : 1'b0;

  assign in_stall           = state_r != S_IDLE;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_region_address = out_region_r;

  `PBA_ASSERT(a_accept_then_busy, (in_valid && !in_stall) |=> in_stall, "accept not followed by busy")
  `PBA_ASSERT_ALWAYS(a_clear_blocks_input, clr_r |-> in_stall, "beat accepted during clearing pass")
  `PBA_ASSERT(a_write_in_range, map_we |-> (i_r < e_r), "bitmap write outside range")
  `PBA_ASSERT(a_no_rw_same_cycle, map_we |-> !map_re, "bitmap read and write in one step")

endmodule

/* rtl/page_bitmap_range_allocator.sv */
// ----------------------------------------------------------------------------
// page_bitmap_range_allocator
// Bitmap page allocator for one node: range reserve, range free and
// first-fit allocation with tail-page sharing.
// ----------------------------------------------------------------------------
//   Port group  Direction  Handshake        Contents
//   in_*        input      valid / stall    command, range, request fields
//   out_*       output     valid / stall    status, region address
//   cfg_*       APB        psel / penable   node start and end page
//
// Each page visited takes a read step, then an evaluate step, on the single
// bitmap port; a write pass writes its pages in turn. Reserve and free add
// setup and hand-off states (RF1, RF2, DONE), allocate setup states (AL1 to
// AL3) and tail states (TAIL1 to TAIL3) beyond its scan and fill. Reserve/free
// scale with the range length, allocate with the pages scanned. After reset
// the clearing pass sets every page with in_stall high. One result waits in
// the output register, so the next beat is taken while out_stall holds it.
// ----------------------------------------------------------------------------
module page_bitmap_range_allocator
  import pba_pkg::*;
#(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_command,
  input  logic [AW-1:0]     in_address,
  input  logic [SW-1:0]     in_byte_count,
  input  logic [SW-1:0]     in_alignment,
  input  logic [AW-1:0]     in_preferred_address,
  input  logic [AW-1:0]     in_upper_limit,
  input  logic              in_exclusive,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [AW-1:0]     out_region_address,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int IW = $clog2(PAGE_COUNT);

  logic [CFGW-1:0] node_start;
  logic [CFGW-1:0] node_end;
  logic            map_re;
  logic [IW-1:0]   map_raddr;
  logic            map_rdata;
  logic            map_we;
  logic [IW-1:0]   map_waddr;
  logic            map_wdata;

  pba_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .node_start  (node_start),
    .node_end    (node_end)
  );

  pba_map_ram #(
    .PAGE_COUNT (PAGE_COUNT),
    .IW         (IW)
  ) u_map (
    .clk   (clk),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata)
  );

  pba_engine #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_BITS  (PAGE_BITS),
    .IW         (IW)
  ) u_engine (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_address           (in_address),
    .in_byte_count        (in_byte_count),
    .in_alignment         (in_alignment),
    .in_preferred_address (in_preferred_address),
    .in_upper_limit       (in_upper_limit),
    .in_exclusive         (in_exclusive),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_region_address   (out_region_address),
    .node_start           (node_start),
    .node_end             (node_end),
    .map_re               (map_re),
    .map_raddr            (map_raddr),
    .map_rdata            (map_rdata),
    .map_we               (map_we),
    .map_waddr            (map_waddr),
    .map_wdata            (map_wdata)
  );

endmodule

/* tb/page_bitmap_range_allocator_tb.sv */
// ----------------------------------------------------------------------------
// page_bitmap_range_allocator_tb
// Drives reserve, free and allocate requests into the page bitmap allocator
// across several node windows, predicts each status and region address from
// its own copy of the page map, and checks every result beat in order.
// ----------------------------------------------------------------------------
module page_bitmap_range_allocator_tb;
  import pba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int      PAGES     = PAGE_COUNT_DEF;
  localparam int      PBITS     = PAGE_BITS_DEF;
  localparam longint  CYCLE_CAP = 40_000_000;
  localparam logic [CFG_AW-1:0] ADDR_NODE_START = CFG_AW'(8 * REG_NODE_START);
  localparam logic [CFG_AW-1:0] ADDR_NODE_END   = CFG_AW'(8 * REG_NODE_END);

  typedef struct packed {
    logic [1:0]    status;
    logic [AW-1:0] region;
  } alloc_result_t;

  class alloc_scoreboard;
    bit            page_map [PAGES];
    bit [63:0]     hint;
    bit [63:0]     last_end;
    bit [63:0]     node_start;
    bit [63:0]     node_end;
    alloc_result_t pending[$];
    int            mismatches;

    function void clear();
      foreach (page_map[i]) page_map[i] = 1'b1;
      hint = 0;
      last_end = 0;
      node_start = NODE_START_RST;
      node_end = NODE_END_RST;
      mismatches = 0;
    endfunction

    function bit [63:0] rup(bit [63:0] x, bit [63:0] a);
      return (x + a - 1) & ~(a - 1);
    endfunction

    function bit [63:0] span_pages();
      bit [63:0] n;
      if (node_end <= node_start) return 0;
      n = node_end - node_start;
      return (n > PAGES) ? PAGES : n;
    endfunction

    function bit off_node(bit [63:0] addr, bit [63:0] size);
      return ((addr + size) < (node_start << PBITS)) || ((addr >> PBITS) > node_end);
    endfunction

    function logic [1:0] reserve_range(bit [63:0] addr, bit [63:0] size, bit excl);
      bit [63:0] base, np, s, e;
      base = node_start << PBITS;
      np = span_pages();
      if (off_node(addr, size)) return ST_OK;
      s = (addr > base) ? (addr - base) >> PBITS : 0;
      e = (addr + size - base + (64'd1 << PBITS) - 1) >> PBITS;
      if (e > np) e = np;
      if (excl)
        for (bit [63:0] i = s; i < e; i++)
          if (page_map[i]) return ST_BUSY;
      for (bit [63:0] i = s; i < e; i++) page_map[i] = 1'b1;
      return ST_OK;
    endfunction

    function logic [1:0] free_range(bit [63:0] addr, bit [63:0] size);
      bit [63:0] base, np, s, e, up;
      bit dbl;
      base = node_start << PBITS;
      np = span_pages();
      dbl = 0;
      if (off_node(addr, size)) return ST_OK;
      if (addr >= base && ((addr - base) >> PBITS) < hint) hint = (addr - base) >> PBITS;
      up = (addr + (64'd1 << PBITS) - 1) >> PBITS;
      s = (up > node_start) ? up - node_start : 0;
      e = (addr + size - base) >> PBITS;
      if (e > np) e = np;
      for (bit [63:0] i = s; i < e; i++) begin
        if (!page_map[i]) dbl = 1;
        page_map[i] = 1'b0;
      end
      return dbl ? ST_DFREE : ST_OK;
    endfunction

    // first fit starting at page s; pos gets the first page of the run
    function bit find_run(bit [63:0] s, bit [63:0] midx, bit [63:0] step,
                          bit [63:0] need, output bit [63:0] pos);
      bit [63:0] e, n;
      bit hit;
      pos = 0;
      forever begin
        hit = 0;
        while (s < midx && page_map[s]) s++;
        s = rup(s, step);
        e = s + need;
        if (s >= midx || e > midx) return 0;
        for (bit [63:0] i = s; i < e; i++) begin
          if (page_map[i]) begin
            n = rup(i, step);
            if (n == i) n += step;
            s = n;
            hit = 1;
            break;
          end
        end
        if (!hit) begin
          pos = s;
          return 1;
        end
      end
    endfunction

    function logic [1:0] allocate(bit [63:0] size, bit [63:0] align, bit [63:0] goal,
                                  bit [63:0] limit, output bit [63:0] region);
      bit [63:0] a, bal, step, minp, maxp, lp, gp, start, sidx, midx, need, pos;
      bit [63:0] so, eo, merge;
      bit retry;
      region = 0;
      a = align & (~align + 1);
      bal = a ? a : 1;
      step = (a >> PBITS) ? (a >> PBITS) : 1;
      minp = node_start;
      maxp = node_end;
      lp = limit >> PBITS;
      gp = goal >> PBITS;
      if (lp != 0 && maxp > lp) maxp = lp;
      if (maxp <= minp) return ST_NOSPACE;
      if (gp != 0 && minp < gp && gp < maxp) start = rup(gp, step);
      else start = rup(minp, step);
      sidx = start - minp;
      midx = maxp - minp;
      if (midx > PAGES) midx = PAGES;
      retry = (gp != 0);
      if (hint > sidx) begin
        retry = 1;
        sidx = rup(hint, step);
      end
      need = (size + (64'd1 << PBITS) - 1) >> PBITS;
      while (!find_run(sidx, midx, step, need, pos)) begin
        if (!retry) return ST_NOSPACE;
        retry = 0;
        sidx = 0;
      end
      // share the partly used tail page of the previous allocation
      if ((last_end & ((64'd1 << PBITS) - 1)) != 0 && (last_end >> PBITS) + 1 == pos)
        so = rup(last_end, bal);
      else
        so = pos << PBITS;
      merge = ((so >> PBITS) < pos) ? 1 : 0;
      eo = so + size;
      last_end = eo;
      hint = (eo + (64'd1 << PBITS) - 1) >> PBITS;
      for (bit [63:0] i = (so >> PBITS) + merge; i < hint && i < midx; i++)
        page_map[i] = 1'b1;
      region = ((node_start << PBITS) + so) & 64'hFFFF_FFFF_FFFF;
      return ST_OK;
    endfunction

    function void note_request(logic [1:0] cmd, logic [AW-1:0] addr, logic [SW-1:0] count,
                               logic [SW-1:0] align, logic [AW-1:0] goal,
                               logic [AW-1:0] limit, logic excl);
      alloc_result_t r;
      bit [63:0] size, region;
      size = (count == 0) ? 1 : count;
      region = 0;
      r.status = ST_OK;
      case (cmd)
        CMD_RESERVE: r.status = reserve_range(addr, size, excl);
        CMD_FREE:    r.status = free_range(addr, size);
        CMD_ALLOC:   r.status = allocate(size, align, goal, limit, region);
        default:     r.status = ST_OK;
      endcase
      r.region = region[AW-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [AW-1:0] region);
      alloc_result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result beat with nothing expected: status %0d region %h",
                   status, region);
        return;
      end
      exp_r = pending.pop_front();
      if (status !== exp_r.status || region !== exp_r.region) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: status exp %0d got %0d, region exp %h got %h",
                   exp_r.status, status, exp_r.region, region);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_command;
  logic [AW-1:0]     in_address;
  logic [SW-1:0]     in_byte_count;
  logic [SW-1:0]     in_alignment;
  logic [AW-1:0]     in_preferred_address;
  logic [AW-1:0]     in_upper_limit;
  logic              in_exclusive;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_status;
  logic [AW-1:0]     out_region_address;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  alloc_scoreboard sb;
  bit              tx_idle_en;
  bit              rx_idle_en;
  int              hold_cycles;
  longint          cycle_count;

  page_bitmap_range_allocator uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_address           (in_address),
    .in_byte_count        (in_byte_count),
    .in_alignment         (in_alignment),
    .in_preferred_address (in_preferred_address),
    .in_upper_limit       (in_upper_limit),
    .in_exclusive         (in_exclusive),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_region_address   (out_region_address),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_prdata           (cfg_prdata),
    .cfg_pready           (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_request(in_command, in_address, in_byte_count, in_alignment,
                      in_preferred_address, in_upper_limit, in_exclusive);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_region_address);
  end

  // receiver: long hold when requested, else random stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall = 1'b1;
        hold_cycles--;
      end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(0, 13)) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_beat(input logic [1:0] cmd, input logic [AW-1:0] addr,
                           input logic [SW-1:0] count, input logic [SW-1:0] align,
                           input logic [AW-1:0] goal, input logic [AW-1:0] limit,
                           input logic excl);
    @(negedge clk);
    in_valid = 1'b1;
    in_command = cmd;
    in_address = addr;
    in_byte_count = count;
    in_alignment = align;
    in_preferred_address = goal;
    in_upper_limit = limit;
    in_exclusive = excl;
    do @(posedge clk); while (in_stall);
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 13)) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = addr;
    cfg_pwdata = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic set_node(input logic [CFGW-1:0] first_page, input logic [CFGW-1:0] end_page);
    drain();
    cfg_write(ADDR_NODE_START, CFG_DW'(first_page));
    cfg_write(ADDR_NODE_END, CFG_DW'(end_page));
    sb.node_start = first_page;
    sb.node_end = end_page;
  endtask

  function automatic logic [SW-1:0] pick_align();
    case ($urandom_range(0, 5))
      0, 1:    return '0;
      2, 3:    return SW'(1) << $urandom_range(0, 15);
      4:       return SW'(1) << $urandom_range(16, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [AW-1:0] rand48();
    return AW'({$urandom(), $urandom()});
  endfunction

  // random beats aimed mostly inside the node window
  task automatic run_random(input int count);
    logic [AW-1:0] base, span, addr, goal, limit;
    logic [1:0]    cmd;
    logic [SW-1:0] bytes;
    int            pages;
    base = AW'(sb.node_start) << PBITS;
    pages = (sb.span_pages() == 0) ? 64 : int'(sb.span_pages());
    span = AW'(pages) << PBITS;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 19))
        0:               cmd = CMD_UNUSED;
        1, 2, 3, 4, 5:   cmd = CMD_RESERVE;
        6, 7, 8, 9, 10:  cmd = CMD_FREE;
        default:         cmd = CMD_ALLOC;
      endcase
      case ($urandom_range(0, 9))
        0:       bytes = $urandom();
        1:       bytes = '0;
        2, 3:    bytes = $urandom_range(1, 4096);
        default: bytes = $urandom_range(1, 6 * 4096);
      endcase
      addr = ($urandom_range(0, 15) == 0) ? rand48() :
             base + AW'({$urandom(), $urandom()} % span);
      case ($urandom_range(0, 5))
        0, 1, 2: goal = '0;
        3:       goal = rand48();
        default: goal = base + AW'({$urandom(), $urandom()} % span);
      endcase
      case ($urandom_range(0, 5))
        0, 1, 2: limit = '0;
        3:       limit = rand48();
        default: limit = base + AW'({$urandom(), $urandom()} % (span + 8192));
      endcase
      send_beat(cmd, addr, bytes, pick_align(), goal, limit, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    cycle_count = 0;
    hold_cycles = 0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_RESERVE;
    in_address = '0;
    in_byte_count = '0;
    in_alignment = '0;
    in_preferred_address = '0;
    in_upper_limit = '0;
    in_exclusive = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // wait out the clearing pass
    do @(posedge clk); while (in_stall);

    // directed: default node, every page starts reserved
    send_beat(CMD_ALLOC,   '0, 32'd4096, '0, '0, '0, 1'b0);
    send_beat(CMD_FREE,    '0, '0, '0, '0, '0, 1'b0);
    send_beat(CMD_FREE,    '0, 32'h40000, '0, '0, '0, 1'b0);
    send_beat(CMD_FREE,    '0, 32'h10000, '0, '0, '0, 1'b0);
    send_beat(CMD_FREE,    48'h100, 32'h3000, '0, '0, '0, 1'b0);
    send_beat(CMD_RESERVE, 48'h4000, 32'h100, '0, '0, '0, 1'b1);
    send_beat(CMD_RESERVE, 48'h4000, 32'h2000, '0, '0, '0, 1'b1);
    send_beat(CMD_ALLOC,   '0, 32'd100, '0, '0, '0, 1'b0);
    send_beat(CMD_ALLOC,   '0, 32'd200, 32'd8, '0, '0, 1'b0);
    send_beat(CMD_ALLOC,   '0, 32'd300, 32'd12, '0, '0, 1'b0);
    send_beat(CMD_ALLOC,   '0, 32'h2000, 32'h4000, 48'h20000, '0, 1'b0);
    send_beat(CMD_ALLOC,   '0, 32'h1000, '0, '0, 48'h30000, 1'b0);
    send_beat(CMD_ALLOC,   '0, 32'h1000, '0, 48'h38000, 48'h30000, 1'b0);
    send_beat(CMD_ALLOC,   '0, 32'hFFFF_FFFF, '0, '0, '0, 1'b0);
    send_beat(CMD_ALLOC,   '0, 32'h1000, 32'h8000_0000, '0, '0, 1'b0);
    send_beat(CMD_RESERVE, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0, 1'b1);
    send_beat(CMD_FREE,    48'hFFFF_FFFF_F000, 32'd1, '0, '0, '0, 1'b0);
    send_beat(CMD_UNUSED,  48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_beat(CMD_FREE,    '0, 32'hFFFF_FFFF, '0, '0, '0, 1'b0);
    send_beat(CMD_FREE,    48'h8000, 32'h1000, '0, '0, '0, 1'b0);
    send_beat(CMD_ALLOC,   '0, 32'h3000, 32'h10000, 48'hFFFF_FFFF_FFFF, '0, 1'b0);
    send_beat(CMD_RESERVE, '0, 32'hFFFF_FFFF, '0, '0, '0, 1'b0);

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    // node windows: small ones mostly, extremes and empty nodes a few times
    set_node(36'd0, 36'd64);
    hold_cycles = 600;
    run_random(180);
    set_node(36'd100, 36'd356);
    run_random(180);
    set_node(36'hF_FFFF_FF00, 36'hF_FFFF_FFFF);
    run_random(160);
    set_node(36'd5000, 36'd5000);
    run_random(60);
    set_node(36'd7, 36'd0);
    run_random(40);
    set_node(36'h1_2345_6000, 36'h1_2345_6200);
    run_random(200);
    set_node(36'd0, 36'hF_FFFF_FFFF);
    run_random(40);
    set_node(36'd32, 36'd160);
    hold_cycles = 500;
    run_random(200);
    set_node(36'd0, 36'd4096);
    run_random(50);
    set_node(36'd1024, 36'd1152);
    run_random(200);

    // last stretch runs without idling
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_node(36'd3, 36'd131);
    run_random(320);

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
